// ===== rtl/core/lzss_flag_byte_decompressor_core_assert.svh =====
// Assertion macros used by the decompressor top module.
`ifndef LZSS_FLAG_BYTE_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZSS_FLAG_BYTE_DECOMPRESSOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFBD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFBD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lfbd_pkg.sv =====
`default_nettype none
package lfbd_pkg;

	localparam int HISTORY_BYTES = 65536;
	localparam int LANES         = 8;
	localparam int MIN_MATCH     = 5;

	localparam int HIST_AW     = $clog2(HISTORY_BYTES);
	localparam int BYTE_W      = 8;
	localparam int POS_W       = 24;
	// 16-bit offset plus up to 259 more bytes of a match
	localparam int SRC_W       = 17;
	localparam int LEN_W       = 9;
	localparam int LANE_CNT_W  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int OUT_BYTES_W = 64;
	localparam int COUNT_W     = 4;
	localparam int STATUS_W    = 2;

	localparam logic [BYTE_W-1:0] FLAG_MASK_INIT = 8'h01;

	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int REG_IDX_LSB  = 2;
	localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_OUTPUT_SIZE = '0;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DATA,
		STATUS_DONE,
		STATUS_OVERRUN,
		STATUS_TRUNC
	} status_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_OFF_LO,
		PH_OFF_HI
	} phase_t;

	typedef enum logic [2:0] {
		TOK_FLAG,
		TOK_LITERAL,
		TOK_OFF_LO,
		TOK_OFF_HI,
		TOK_LENGTH
	} tok_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LITERAL,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_END,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic    take_in;
		logic    decode;
		logic    emit_lit;
		logic    copy_step;
		logic    load_status;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic finished;
		logic size_reached;
		tok_t tok;
		logic overrun;
		logic copy_last;
		logic lane_full;
		logic out_free;
		logic open_token;
		logic last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lfbd_in_if.sv =====
`default_nettype none
interface lfbd_in_if;
	import lfbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lfbd_out_if.sv =====
`default_nettype none
interface lfbd_out_if;
	import lfbd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OUT_BYTES_W-1:0] out_bytes;
	logic [COUNT_W-1:0]     byte_count;
	logic [STATUS_W-1:0]    status;
	logic [POS_W-1:0]       bytes_done;
	logic                   run_last;

	modport source (output valid, out_bytes, byte_count, status, bytes_done, run_last,
		input ready);
	modport sink (input valid, out_bytes, byte_count, status, bytes_done, run_last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lzss_flag_byte_decompressor_core.sv =====
// LZSS decompressor for flag-byte streams with absolute 16-bit match offsets. One
// compressed byte is taken per request on in_ch; decoded bytes leave on out_ch in
// results of up to eight bytes, then a status result (done, match past end, or
// truncated token) closes the run, after which input is swallowed until reset.
// Program output_size over APB (byte address 0) before the run. Each byte passes
// through idle, dispatch and end states; a literal adds an emit state, and a match
// token a read then a write of the single 64 KiB history RAM per copied byte, and
// overlapping copies see the bytes they just produced. A busy output adds stall.
`default_nettype none
`include "lzss_flag_byte_decompressor_core_assert.svh"
module lzss_flag_byte_decompressor_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	lfbd_in_if.sink                               in_ch,
	lfbd_out_if.source                            out_ch,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lfbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [lfbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [lfbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);
	import lfbd_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             in_ready;
	logic [POS_W-1:0] output_size;

	assign in_ch.ready = in_ready;

	lfbd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.output_size (output_size)
	);

	lfbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfbd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_byte     (in_ch.in_byte),
		.in_last     (in_ch.in_last),
		.output_size (output_size),
		.out_ch      (out_ch)
	);

	`LFBD_ASSERT_IMP(a_status_is_final, clk, arst_n, out_ch.valid && (out_ch.status != STATUS_DATA), out_ch.run_last, "status result not marked final")
	`LFBD_ASSERT_NXT(a_drop_stays_idle, clk, arst_n, in_ch.valid && in_ch.ready && stat.finished, in_ch.ready, "byte after finish was decoded")
	`LFBD_ASSERT_NXT(a_status_sets_finished, clk, arst_n, cmd.load_status, stat.finished, "status result did not end the run")
endmodule
`default_nettype wire

// ===== rtl/core/lfbd_ram.sv =====
`default_nettype none
module lfbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rd_data_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/lfbd_regs.sv =====
`default_nettype none
module lfbd_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lfbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [lfbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [lfbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output logic      [lfbd_pkg::POS_W-1:0]       output_size
);
	import lfbd_pkg::*;

	logic [POS_W-1:0]                   output_size_q;
	logic [APB_ADDR_W-REG_IDX_LSB-1:0]  reg_idx;
	logic                               wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_size_q <= '0;
		end else if (wr_en && (reg_idx == REG_OUTPUT_SIZE)) begin
			output_size_q <= pwdata[POS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_OUTPUT_SIZE) begin
			prdata = APB_DATA_W'(output_size_q);
		end
	end

	assign output_size = output_size_q;
endmodule
`default_nettype wire

// ===== rtl/core/lfbd_dp.sv =====
`default_nettype none
module lfbd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lfbd_pkg::dp_cmd_t             cmd,
	output lfbd_pkg::dp_stat_t                 stat,
	input  wire logic [lfbd_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic                          in_last,
	input  wire logic [lfbd_pkg::POS_W-1:0]    output_size,
	lfbd_out_if.source                         out_ch
);
	import lfbd_pkg::*;

	// held request and token state
	logic [BYTE_W-1:0]      byte_q;
	logic                   last_q;
	logic [BYTE_W-1:0]      flag_bits_q;
	logic [BYTE_W-1:0]      mask_q;
	phase_t                 phase_q;
	logic [BYTE_W-1:0]      off_lo_q;
	logic [BYTE_W-1:0]      off_hi_q;
	logic                   finished_q;
	logic [POS_W-1:0]       wp_q;

	// copy engine
	logic [SRC_W-1:0]       src_q;
	logic [LEN_W-1:0]       rem_q;
	logic [OUT_BYTES_W-1:0] lane_acc_q;
	logic [LANE_CNT_W-1:0]  lane_cnt_q;

	// result register
	logic                   out_valid_q;
	logic [OUT_BYTES_W-1:0] out_bytes_q;
	logic [COUNT_W-1:0]     out_count_q;
	status_t                out_status_q;
	logic [POS_W-1:0]       out_done_q;
	logic                   out_last_q;

	tok_t                   tok;
	logic [LEN_W-1:0]       match_len;
	logic [POS_W-1:0]       wp_inc;
	logic                   src_valid;
	logic [BYTE_W-1:0]      ram_rd;
	logic [BYTE_W-1:0]      copy_byte;
	logic [OUT_BYTES_W-1:0] lane_next;
	logic                   copy_last;
	logic                   lane_full;
	logic                   flush;
	logic                   end_after;
	logic                   out_free;
	logic                   load_out;
	logic                   hist_we;
	logic [BYTE_W-1:0]      hist_wdata;

	always_comb begin
		if (mask_q == '0) begin
			tok = TOK_FLAG;
		end else if ((phase_q == PH_START) && ((flag_bits_q & mask_q) != '0)) begin
			tok = TOK_LITERAL;
		end else if (phase_q == PH_START) begin
			tok = TOK_OFF_LO;
		end else if (phase_q == PH_OFF_LO) begin
			tok = TOK_OFF_HI;
		end else begin
			tok = TOK_LENGTH;
		end
	end

	assign match_len = LEN_W'(byte_q) + LEN_W'(MIN_MATCH);
	assign wp_inc    = wp_q + POS_W'(1);

	// source at or past the write position, or outside history, reads as zero
	assign src_valid = (src_q < SRC_W'(HISTORY_BYTES)) && (POS_W'(src_q) < wp_q);
	assign copy_byte = src_valid ? ram_rd : '0;
	assign lane_next = lane_acc_q | (OUT_BYTES_W'(copy_byte) << {lane_cnt_q, 3'b000});
	assign copy_last = (rem_q == LEN_W'(1));
	assign lane_full = (lane_cnt_q == LANE_CNT_W'(LANES - 1));
	assign flush     = lane_full || copy_last;
	// a status result will follow this token's last data result
	assign end_after = (wp_inc >= output_size) || last_q;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign load_out  = cmd.emit_lit || (cmd.copy_step && flush) || cmd.load_status;

	assign hist_we    = (cmd.emit_lit || cmd.copy_step) && (wp_q < POS_W'(HISTORY_BYTES));
	assign hist_wdata = cmd.emit_lit ? byte_q : copy_byte;

	lfbd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (HISTORY_BYTES)
	) u_history (
		.clk       (clk),
		.we        (hist_we),
		.waddr     (wp_q[HIST_AW-1:0]),
		.wdata     (hist_wdata),
		.raddr     (src_q[HIST_AW-1:0]),
		.rd_data_q (ram_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.decode && (tok == TOK_LENGTH)) begin
			src_q      <= {1'b0, off_hi_q, off_lo_q};
			rem_q      <= match_len;
			lane_acc_q <= '0;
		end else if (cmd.copy_step) begin
			src_q      <= src_q + SRC_W'(1);
			rem_q      <= rem_q - LEN_W'(1);
			lane_acc_q <= flush ? '0 : lane_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q <= '0;
			mask_q      <= '0;
			phase_q     <= PH_START;
			off_lo_q    <= '0;
			off_hi_q    <= '0;
			finished_q  <= 1'b0;
			wp_q        <= '0;
			lane_cnt_q  <= '0;
		end else begin
			if (cmd.decode) begin
				case (tok)
					TOK_FLAG: begin
						flag_bits_q <= byte_q;
						mask_q      <= FLAG_MASK_INIT;
					end
					TOK_LITERAL: begin
						mask_q <= mask_q << 1;
					end
					TOK_OFF_LO: begin
						off_lo_q <= byte_q;
						phase_q  <= PH_OFF_LO;
					end
					TOK_OFF_HI: begin
						off_hi_q <= byte_q;
						phase_q  <= PH_OFF_HI;
					end
					TOK_LENGTH: begin
						phase_q    <= PH_START;
						mask_q     <= mask_q << 1;
						lane_cnt_q <= '0;
					end
					default: begin
						phase_q <= PH_START;
					end
				endcase
			end
			if (cmd.emit_lit || cmd.copy_step) begin
				wp_q <= wp_inc;
			end
			if (cmd.copy_step) begin
				lane_cnt_q <= flush ? '0 : lane_cnt_q + LANE_CNT_W'(1);
			end
			if (cmd.load_status) begin
				finished_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_lit) begin
			out_bytes_q  <= OUT_BYTES_W'(byte_q);
			out_count_q  <= COUNT_W'(1);
			out_status_q <= STATUS_DATA;
			out_done_q   <= '0;
			out_last_q   <= !end_after;
		end else if (cmd.copy_step && flush) begin
			out_bytes_q  <= lane_next;
			out_count_q  <= COUNT_W'(lane_cnt_q) + COUNT_W'(1);
			out_status_q <= STATUS_DATA;
			out_done_q   <= '0;
			out_last_q   <= copy_last && !end_after;
		end else if (cmd.load_status) begin
			out_bytes_q  <= '0;
			out_count_q  <= '0;
			out_status_q <= cmd.code;
			out_done_q   <= wp_q;
			out_last_q   <= 1'b1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_bytes  = out_bytes_q;
	assign out_ch.byte_count = out_count_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.bytes_done = out_done_q;
	assign out_ch.run_last   = out_last_q;

	assign stat.finished     = finished_q;
	assign stat.size_reached = (wp_q >= output_size);
	assign stat.tok          = tok;
	assign stat.overrun      = ({1'b0, wp_q} + (POS_W+1)'(match_len)) > {1'b0, output_size};
	assign stat.copy_last    = copy_last;
	assign stat.lane_full    = lane_full;
	assign stat.out_free     = out_free;
	assign stat.open_token   = (phase_q != PH_START);
	assign stat.last         = last_q;
endmodule
`default_nettype wire

// ===== rtl/core/lfbd_ctrl.sv =====
`default_nettype none
module lfbd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lfbd_pkg::dp_stat_t stat,
	output lfbd_pkg::dp_cmd_t       cmd
);
	import lfbd_pkg::*;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    copy_go;

	// a flushing copy byte must find the result register free
	assign copy_go = !(stat.lane_full || stat.copy_last) || stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= STATUS_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.finished ? ST_IDLE : ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.size_reached) begin
					state_d = ST_STATUS;
					code_d  = STATUS_DONE;
				end else begin
					case (stat.tok)
						TOK_LITERAL: state_d = ST_LITERAL;
						TOK_LENGTH: begin
							if (stat.overrun) begin
								state_d = ST_STATUS;
								code_d  = STATUS_OVERRUN;
							end else begin
								state_d = ST_COPY_RD;
							end
						end
						default: state_d = ST_END;
					endcase
				end
			end
			ST_LITERAL: begin
				if (stat.out_free) begin
					state_d = ST_END;
				end
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				if (copy_go) begin
					state_d = stat.copy_last ? ST_END : ST_COPY_RD;
				end
			end
			ST_END: begin
				if (stat.size_reached) begin
					state_d = ST_STATUS;
					code_d  = STATUS_DONE;
				end else if (stat.last) begin
					state_d = ST_STATUS;
					code_d  = stat.open_token ? STATUS_TRUNC : STATUS_DONE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.code        = code_q;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
			end
			ST_DISPATCH: begin
				cmd.decode = !stat.size_reached;
			end
			ST_LITERAL: begin
				cmd.emit_lit = stat.out_free;
			end
			ST_COPY_WR: begin
				cmd.copy_step = copy_go;
			end
			ST_STATUS: begin
				cmd.load_status = stat.out_free;
			end
			default: begin
				cmd.take_in = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== tb/lzss_flag_byte_decompressor_core_tb.sv =====
`timescale 1ns / 1ps
module lzss_flag_byte_decompressor_core_tb;
	import lfbd_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [APB_ADDR_W-1:0] OSIZE_ADDR = {REG_OUTPUT_SIZE, {REG_IDX_LSB{1'b0}}};

	typedef struct packed {
		logic [OUT_BYTES_W-1:0] out_bytes;
		logic [COUNT_W-1:0]     byte_count;
		status_t                status;
		logic [POS_W-1:0]       bytes_done;
		logic                   run_last;
	} result_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        fixed;
		logic [63:0] ob;
		logic [3:0]  cnt;
	} step_row_t;

	// Opening stream: literals at both extremes, then matches covering an overlapping
	// max-length copy, a source past the written range, and a source right at write_pos.
	localparam step_row_t DIR_TAB [0:21] = '{
		'{8'hFF, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b1, 64'h0, 4'd1},
		'{8'hFF, 1'b1, 64'hFF, 4'd1},
		'{8'hA5, 1'b0, 64'h0, 4'd0},
		'{8'h5A, 1'b0, 64'h0, 4'd0},
		'{8'h01, 1'b0, 64'h0, 4'd0},
		'{8'h80, 1'b0, 64'h0, 4'd0},
		'{8'h3C, 1'b0, 64'h0, 4'd0},
		'{8'hC3, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b0, 64'h0, 4'd0},
		'{8'h06, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b0, 64'h0, 4'd0},
		'{8'hFF, 1'b0, 64'h0, 4'd0},
		'{8'hFF, 1'b0, 64'h0, 4'd0},
		'{8'hFF, 1'b0, 64'h0, 4'd0},
		'{8'h03, 1'b1, 64'h0, 4'd8},
		'{8'h19, 1'b0, 64'h0, 4'd0},
		'{8'h01, 1'b0, 64'h0, 4'd0},
		'{8'h00, 1'b1, 64'h0, 4'd5}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	lfbd_in_if in_ch();
	lfbd_out_if out_ch();

	lzss_flag_byte_decompressor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// decoder shadow state
	logic [7:0]       hist [0:HISTORY_BYTES-1];
	logic [POS_W-1:0] m_wpos;
	logic [POS_W-1:0] m_osize;
	logic [7:0]       m_fbits;
	logic [7:0]       m_fmask;
	logic [7:0]       m_off_lo;
	logic [7:0]       m_off_hi;
	phase_t           m_phase;
	logic             m_fin;
	logic [63:0]      lane_acc;
	int               lane_n;

	result_t step_out[$];
	result_t decoded_q[$];

	logic [15:0] pend_off;
	bit tx_idle;
	bit rx_idle;
	int rx_hold;
	int n_fail;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, decoded_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic string fmt_res(result_t r);
		return $sformatf("bytes=%h cnt=%0d status=%0d done=%0d last=%0b",
			r.out_bytes, r.byte_count, r.status, r.bytes_done, r.run_last);
	endfunction

	task automatic fail_msg(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t ERROR %s", $realtime, msg);
	endtask

	function automatic void put_status(status_t s);
		step_out.push_back('{64'h0, 4'd0, s, m_wpos, 1'b0});
		m_fin = 1'b1;
	endfunction

	function automatic void flush_lanes();
		if (lane_n != 0) begin
			step_out.push_back('{lane_acc, 4'(lane_n), STATUS_DATA, 24'h0, 1'b0});
			lane_acc = '0;
			lane_n = 0;
		end
	endfunction

	function automatic void put_byte(logic [7:0] v);
		if (m_wpos < HISTORY_BYTES)
			hist[m_wpos[15:0]] = v;
		m_wpos = m_wpos + 1'b1;
		lane_acc[8*lane_n +: 8] = v;
		lane_n++;
		if (lane_n >= LANES)
			flush_lanes();
	endfunction

	// Expected results of one accepted compressed byte, left in step_out.
	function automatic void decode_byte(logic [7:0] b, logic last);
		int unsigned len;
		int unsigned src;
		int unsigned s;
		logic [7:0] v;
		result_t r;
		step_out.delete();
		if (m_fin)
			return;
		lane_acc = '0;
		lane_n = 0;
		if (m_wpos >= m_osize) begin
			put_status(STATUS_DONE);
		end else begin
			if (m_fmask == 8'h00) begin
				m_fbits = b;
				m_fmask = FLAG_MASK_INIT;
			end else if (m_phase == PH_START && (m_fbits & m_fmask) != 8'h00) begin
				put_byte(b);
				flush_lanes();
				m_fmask = m_fmask << 1;
			end else if (m_phase == PH_START) begin
				m_off_lo = b;
				m_phase = PH_OFF_LO;
			end else if (m_phase == PH_OFF_LO) begin
				m_off_hi = b;
				m_phase = PH_OFF_HI;
			end else begin
				len = b + MIN_MATCH;
				src = {m_off_hi, m_off_lo};
				m_phase = PH_START;
				m_fmask = m_fmask << 1;
				if (m_wpos + len > m_osize) begin
					put_status(STATUS_OVERRUN);
				end else begin
					for (int unsigned i = 0; i < len; i++) begin
						s = src + i;
						v = 8'h00;
						// bytes not yet produced, or past the kept window, read as zero
						if (s < m_wpos && s < HISTORY_BYTES)
							v = hist[s[15:0]];
						put_byte(v);
					end
					flush_lanes();
				end
			end
			if (!m_fin) begin
				if (m_wpos >= m_osize)
					put_status(STATUS_DONE);
				else if (last)
					put_status((m_phase != PH_START) ? STATUS_TRUNC : STATUS_DONE);
			end
		end
		if (step_out.size() > 0) begin
			r = step_out.pop_back();
			r.run_last = 1'b1;
			step_out.push_back(r);
		end
	endfunction

	// Next byte of a mostly well-formed stream, driven by the decoder's current state.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom);
		if (m_fmask == 8'h00) begin
			case ($urandom_range(0, 3))
				0: return 8'hFF;
				1: return 8'h00;
				default: return 8'($urandom);
			endcase
		end
		if (m_phase == PH_START && (m_fbits & m_fmask) != 8'h00)
			return 8'($urandom);
		if (m_phase == PH_START) begin
			case ($urandom_range(0, 5))
				0: pend_off = 16'h0000;
				1: pend_off = 16'hFFFF;
				2: pend_off = m_wpos[15:0] - 16'd1;
				3: pend_off = m_wpos[15:0];
				default: pend_off = 16'($urandom_range(0, (m_wpos > 65535) ? 65535 : int'(m_wpos)));
			endcase
			return pend_off[7:0];
		end
		if (m_phase == PH_OFF_LO)
			return pend_off[15:8];
		case ($urandom_range(0, 5))
			0: return 8'hFF;
			1: return 8'($urandom);
			default: return 8'($urandom_range(0, 12));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last,
		input bit use_fixed = 1'b0, input result_t fixed_res = '0);
		int gap;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		decode_byte(b, last);
		if (use_fixed)
			decoded_q.push_back(fixed_res);
		else
			foreach (step_out[i]) decoded_q.push_back(step_out[i]);
	endtask

	// drop the request and wait until every decoded result has come out
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(logic [POS_W-1:0] v);
		logic [APB_DATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= OSIZE_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		m_osize = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(m_osize))
			fail_msg($sformatf("output_size readback %h, wrote %h", rd, m_osize));
	endtask

	// finish the open token and flag group so the next byte is a flag byte
	task automatic align_tokens();
		while (m_fmask != 8'h00 || m_phase != PH_START)
			send_byte((m_phase == PH_OFF_HI) ? 8'($urandom_range(0, 3)) : 8'($urandom), 1'b0);
	endtask

	task automatic run_random(int n, bit allow_idle);
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				tx_idle = allow_idle && ($urandom_range(0, 3) != 0);
				rx_idle = allow_idle && ($urandom_range(0, 3) != 0);
			end
			send_byte(pick_byte(), 1'b0);
		end
	endtask

	initial begin : rx_side
		int rx_gap;
		rx_gap = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				out_ch.ready <= 1'b0;
				rx_gap--;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				rx_gap = $urandom_range(0, 4);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.out_bytes, out_ch.byte_count, status_t'(out_ch.status),
				out_ch.bytes_done, out_ch.run_last};
			if (decoded_q.size() == 0) begin
				fail_msg({"result with nothing pending: ", fmt_res(got)});
			end else begin
				want = decoded_q.pop_front();
				if (got !== want)
					fail_msg({"got ", fmt_res(got), " want ", fmt_res(want)});
			end
		end
	end

	initial begin : stim
		result_t fixed_res;
		logic [15:0] fill_off;
		logic flag_last;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		n_fail = 0;
		cycles = 0;
		m_wpos = '0;
		m_osize = '0;
		m_fbits = '0;
		m_fmask = '0;
		m_off_lo = '0;
		m_off_hi = '0;
		m_phase = PH_START;
		m_fin = 1'b0;
		pend_off = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_size(24'h000000);
		set_size(24'hFFFFFF);
		foreach (DIR_TAB[i]) begin
			fixed_res = '{DIR_TAB[i].ob, DIR_TAB[i].cnt, STATUS_DATA, 24'h0, 1'b1};
			send_byte(DIR_TAB[i].b, 1'b0, DIR_TAB[i].fixed, fixed_res);
		end

		settle();
		set_size(24'($urandom_range(150000, 24'hFFFFFE)));
		run_random(100, 1'b1);
		// long output stall while requests keep coming
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = 600;
		run_random(60, 1'b0);
		settle();
		run_random(60, 1'b1);

		// groups of long matches, some overlapping their own output, some at random offsets
		settle();
		set_size(24'($urandom_range(150000, 24'hFFFFFE)));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		align_tokens();
		repeat (4) begin
			send_byte(8'h00, 1'b0);
			repeat (8) begin
				fill_off = $urandom_range(0, 1) ? m_wpos[15:0] - 16'($urandom_range(1, 64))
					: 16'($urandom);
				send_byte(fill_off[7:0], 1'b0);
				send_byte(fill_off[15:8], 1'b0);
				send_byte(8'($urandom_range(240, 255)), 1'b0);
			end
		end
		run_random(40, 1'b1);
		run_random(40, 1'b0);

		// closing condition, picked at random
		settle();
		align_tokens();
		settle();
		case ($urandom_range(0, 4))
			0: begin
				set_size(m_wpos + 24'd3);
				send_byte(8'hFF, 1'b0);
				repeat (3) send_byte(8'($urandom), 1'b0);
			end
			1: begin
				set_size(m_wpos);
				send_byte(8'($urandom), 1'b1);
			end
			2: begin
				set_size(m_wpos + 24'd10);
				send_byte(8'h00, 1'b0);
				send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom_range(6, 255)), 1'b1);
			end
			3: begin
				send_byte(8'h00, 1'b0);
				flag_last = 1'($urandom_range(0, 1));
				send_byte(8'($urandom), flag_last);
				if (!flag_last)
					send_byte(8'($urandom), 1'b1);
			end
			default: begin
				flag_last = 1'($urandom_range(0, 1));
				send_byte(8'hFF, flag_last);
				if (!flag_last)
					send_byte(8'($urandom), 1'b1);
			end
		endcase
		// finished: these are swallowed without results
		repeat (12) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
		settle();

		if (decoded_q.size() != 0)
			fail_msg($sformatf("%0d results never arrived", decoded_q.size()));
		if (n_fail == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lfbd_pkg.sv
rtl/core/lfbd_in_if.sv
rtl/core/lfbd_out_if.sv
rtl/core/lfbd_ram.sv
rtl/core/lfbd_regs.sv
rtl/core/lfbd_dp.sv
rtl/core/lfbd_ctrl.sv
rtl/core/lzss_flag_byte_decompressor_core.sv
tb/lzss_flag_byte_decompressor_core_tb.sv
